>>> rtl/core/vse_pkg.sv
// Shared constants, types and small arithmetic helpers of the voxel surface normal encoder.
// Used by the channel interfaces, the gather and classify stages and the top.
`default_nettype none

package vse_pkg;

	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int MAX_DEPTH  = 64;

	localparam int COORD_W  = 6;
	localparam int DIM_W    = 7;
	localparam int COLUMN_W = 64;
	localparam int COLOR_W  = 32;
	localparam int MAT_W    = 8;
	localparam int ENC_W    = 30;
	localparam int NORMAL_W = 5;
	localparam int CUBE_W   = 27;

	// Columns are split over 3x3 banks by (x mod 3, y mod 3).
	localparam int BANK_COLS  = (MAX_WIDTH + 2) / 3;
	localparam int BANK_ROWS  = (MAX_HEIGHT + 2) / 3;
	localparam int BANK_DEPTH = BANK_COLS * BANK_ROWS;
	localparam int BANK_AW    = $clog2(BANK_DEPTH);
	localparam int QUOT_W     = 5;

	localparam logic [NORMAL_W-1:0] NORMAL_EMISSIVE = 5'd27;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef enum logic [1:0] {
		CFG_MODEL_WIDTH   = 2'd0,
		CFG_MODEL_HEIGHT  = 2'd1,
		CFG_MODEL_DEPTH   = 2'd2,
		CFG_EMISSIVE_CODE = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic [CUBE_W-1:0]  cube;   // bit 9*k+3*j+i is cell (x+i-1, y+j-1, z+k-1)
		logic [COORD_W-1:0] z;
		logic [COLOR_W-1:0] color;
	} cube_t;

	typedef struct packed {
		logic                hit;
		logic [ENC_W-1:0]    encoded_color;
		logic [NORMAL_W-1:0] normal_code;
	} result_t;

	// Quotient by 3 of a 6-bit value through the reciprocal 43/128.
	function automatic logic [QUOT_W-1:0] div3_f(input logic [COORD_W-1:0] v);
		logic [11:0] p;
		p = 12'(v) * 12'd43;
		return p[11:7];
	endfunction

	function automatic logic [1:0] mod3_f(input logic [COORD_W-1:0] v);
		logic [QUOT_W-1:0] q;
		logic [COORD_W-1:0] r;
		q = div3_f(v);
		r = v - COORD_W'(q) * COORD_W'(3);
		return r[1:0];
	endfunction

	// Reduce a value 0..6 mod 3.
	function automatic logic [1:0] wrap3_f(input logic [2:0] s);
		logic [2:0] r;
		if (s >= 3'd6) begin
			r = s - 3'd6;
		end else if (s >= 3'd3) begin
			r = s - 3'd3;
		end else begin
			r = s;
		end
		return r[1:0];
	endfunction

	function automatic logic [DIM_W-1:0] dim_clamp_f(input logic [DIM_W-1:0] v, input int maxv);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > DIM_W'(maxv)) begin
			r = DIM_W'(maxv);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [BANK_AW-1:0] bank_addr_f(input logic [QUOT_W-1:0] qy,
			input logic [QUOT_W-1:0] qx);
		return BANK_AW'(BANK_AW'(qy) * BANK_AW'(BANK_COLS) + BANK_AW'(qx));
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/vse_if.sv
// Request and result channel interfaces of the voxel surface normal encoder.
// Depends on vse_pkg for field widths.
`default_nettype none

interface vse_item_if;
	logic                           valid;
	logic                           ready;
	logic                           mode;
	logic [vse_pkg::COORD_W-1:0]    pos_x;
	logic [vse_pkg::COORD_W-1:0]    pos_y;
	logic [vse_pkg::COORD_W-1:0]    pos_z;
	logic [vse_pkg::COLUMN_W-1:0]   column_bits;
	logic [vse_pkg::COLOR_W-1:0]    voxel_color;

	modport source (output valid, mode, pos_x, pos_y, pos_z, column_bits, voxel_color,
		input ready);
	modport sink (input valid, mode, pos_x, pos_y, pos_z, column_bits, voxel_color,
		output ready);
endinterface

interface vse_result_if;
	logic                           valid;
	logic                           ready;
	logic [vse_pkg::ENC_W-1:0]      encoded_color;
	logic [vse_pkg::NORMAL_W-1:0]   normal_code;

	modport source (output valid, encoded_color, normal_code, input ready);
	modport sink (input valid, encoded_color, normal_code, output ready);
endinterface

`default_nettype wire

>>> rtl/core/vse_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
`default_nettype none

module vse_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 484
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/vse_gather.sv
// Occupancy store in 3x3 banks and the read stage that gathers the 3x3x3 neighborhood.
// Depends on vse_pkg and vse_ram.
`default_nettype none

module vse_gather (
	input  wire logic                            clk,
	input  wire logic                            wr_en,
	input  wire logic                            rd_en,
	input  wire logic [vse_pkg::COORD_W-1:0]     pos_x,
	input  wire logic [vse_pkg::COORD_W-1:0]     pos_y,
	input  wire logic [vse_pkg::COORD_W-1:0]     pos_z,
	input  wire logic [vse_pkg::COLUMN_W-1:0]    column_bits,
	input  wire logic [vse_pkg::COLOR_W-1:0]     voxel_color,
	input  wire logic [vse_pkg::DIM_W-1:0]       w_eff,
	input  wire logic [vse_pkg::DIM_W-1:0]       h_eff,
	input  wire logic [vse_pkg::DIM_W-1:0]       d_eff,
	output vse_pkg::cube_t                       cube
);

	logic [1:0] rx, ry;
	logic [vse_pkg::DIM_W-1:0]   xn [3];
	logic [vse_pkg::DIM_W-1:0]   yn [3];
	logic [vse_pkg::QUOT_W-1:0]  qx_n [3];
	logic [vse_pkg::QUOT_W-1:0]  qy_n [3];
	logic [2:0] vx, vy;
	logic [1:0] sel_x [3];
	logic [1:0] sel_y [3];
	logic [vse_pkg::BANK_AW-1:0] wr_addr;
	logic [vse_pkg::BANK_AW-1:0] rd_addr [3][3];
	logic bank_we [3][3];
	logic [vse_pkg::COLUMN_W-1:0] rdata [3][3];

	logic [1:0]                   rx_s1, ry_s1;
	logic [2:0]                   vx_s1, vy_s1;
	logic [vse_pkg::COORD_W-1:0]  z_s1;
	logic [vse_pkg::COLOR_W-1:0]  color_s1;

	logic [vse_pkg::COLUMN_W-1:0] col_n [3][3];
	logic [vse_pkg::DIM_W-1:0]    zn [3];
	logic [2:0]                   vz;

	// Address generation: the three x and three y neighbors land in distinct banks.
	always_comb begin
		rx = vse_pkg::mod3_f(pos_x);
		ry = vse_pkg::mod3_f(pos_y);
		for (int i = 0; i < 3; i++) begin
			xn[i]   = vse_pkg::DIM_W'(pos_x) + vse_pkg::DIM_W'(i) - vse_pkg::DIM_W'(1);
			yn[i]   = vse_pkg::DIM_W'(pos_y) + vse_pkg::DIM_W'(i) - vse_pkg::DIM_W'(1);
			qx_n[i] = vse_pkg::div3_f(xn[i][vse_pkg::COORD_W-1:0]);
			qy_n[i] = vse_pkg::div3_f(yn[i][vse_pkg::COORD_W-1:0]);
			vx[i]   = xn[i] < w_eff;
			vy[i]   = yn[i] < h_eff;
			sel_x[i] = vse_pkg::wrap3_f(3'(i) + 3'd4 - {1'b0, rx});
			sel_y[i] = vse_pkg::wrap3_f(3'(i) + 3'd4 - {1'b0, ry});
		end
		wr_addr = vse_pkg::bank_addr_f(vse_pkg::div3_f(pos_y), vse_pkg::div3_f(pos_x));
		for (int bx = 0; bx < 3; bx++) begin
			for (int by = 0; by < 3; by++) begin
				bank_we[bx][by] = wr_en && (rx == 2'(bx)) && (ry == 2'(by));
				rd_addr[bx][by] = vse_pkg::bank_addr_f(qy_n[sel_y[by]], qx_n[sel_x[bx]]);
			end
		end
	end

	for (genvar gx = 0; gx < 3; gx++) begin : g_bx
		for (genvar gy = 0; gy < 3; gy++) begin : g_by
			vse_ram #(
				.WIDTH(vse_pkg::COLUMN_W),
				.DEPTH(vse_pkg::BANK_DEPTH)
			) u_bank (
				.clk   (clk),
				.we    (bank_we[gx][gy]),
				.waddr (wr_addr),
				.wdata (column_bits),
				.re    (rd_en),
				.raddr (rd_addr[gx][gy]),
				.rdata (rdata[gx][gy])
			);
		end
	end

	// Hold the query alongside the bank read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rx_s1    <= rx;
			ry_s1    <= ry;
			vx_s1    <= vx;
			vy_s1    <= vy;
			z_s1     <= pos_z;
			color_s1 <= voxel_color;
		end
	end

	// Route bank data back to neighbor positions and pick the three z bits of each column.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			zn[k] = vse_pkg::DIM_W'(z_s1) + vse_pkg::DIM_W'(k) - vse_pkg::DIM_W'(1);
			vz[k] = zn[k] < d_eff;
		end
		cube.cube  = '0;
		cube.z     = z_s1;
		cube.color = color_s1;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				col_n[i][j] = rdata[vse_pkg::wrap3_f({1'b0, rx_s1} + 3'(i) + 3'd2)]
					[vse_pkg::wrap3_f({1'b0, ry_s1} + 3'(j) + 3'd2)];
				for (int k = 0; k < 3; k++) begin
					cube.cube[9*k + 3*j + i] = col_n[i][j][zn[k][vse_pkg::COORD_W-1:0]]
						& vx_s1[i] & vy_s1[j] & vz[k];
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/vse_classify.sv
// Surface test, color packing and quantized normal from a 3x3x3 occupancy neighborhood.
// Depends on vse_pkg.
`default_nettype none

module vse_classify (
	input  wire vse_pkg::cube_t               nbhd,
	input  wire logic [vse_pkg::DIM_W-1:0]    d_eff,
	input  wire logic [vse_pkg::MAT_W-1:0]    emissive_code,
	output vse_pkg::result_t                  res
);

	logic       center, surface;
	logic [3:0] cnt_lo [3];
	logic [3:0] cnt_hi [3];
	logic [1:0] axis [3];
	logic [4:0] code;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			cnt_lo[a] = '0;
			cnt_hi[a] = '0;
		end
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++) begin
				for (int i = 0; i < 3; i++) begin
					if (i == 0) cnt_lo[0] = cnt_lo[0] + 4'(nbhd.cube[9*k + 3*j + i]);
					if (i == 2) cnt_hi[0] = cnt_hi[0] + 4'(nbhd.cube[9*k + 3*j + i]);
					if (j == 0) cnt_lo[1] = cnt_lo[1] + 4'(nbhd.cube[9*k + 3*j + i]);
					if (j == 2) cnt_hi[1] = cnt_hi[1] + 4'(nbhd.cube[9*k + 3*j + i]);
					if (k == 0) cnt_lo[2] = cnt_lo[2] + 4'(nbhd.cube[9*k + 3*j + i]);
					if (k == 2) cnt_hi[2] = cnt_hi[2] + 4'(nbhd.cube[9*k + 3*j + i]);
				end
			end
		end
		// Solid cells on the low side push the normal toward positive.
		for (int a = 0; a < 3; a++) begin
			if (cnt_lo[a] > cnt_hi[a]) begin
				axis[a] = 2'd2;
			end else if (cnt_lo[a] == cnt_hi[a]) begin
				axis[a] = 2'd1;
			end else begin
				axis[a] = 2'd0;
			end
		end
		code = 5'(axis[0]) + 5'(axis[1]) * 5'd3 + 5'(axis[2]) * 5'd9;

		center  = nbhd.cube[13];
		surface = (nbhd.z == '0)
			|| (vse_pkg::DIM_W'(nbhd.z) == d_eff - vse_pkg::DIM_W'(1))
			|| !nbhd.cube[12] || !nbhd.cube[14]
			|| !nbhd.cube[10] || !nbhd.cube[16]
			|| !nbhd.cube[4]  || !nbhd.cube[22];

		res.hit = center && surface;
		res.encoded_color = {nbhd.z, nbhd.color[7:0], nbhd.color[15:8], nbhd.color[23:16]};
		if (nbhd.color[31:24] == emissive_code) begin
			res.normal_code = vse_pkg::NORMAL_EMISSIVE;
		end else begin
			res.normal_code = code;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/voxel_surface_normal_encoder.sv
// Top level of the voxel surface normal encoder: config registers, pipeline control, output.
// Depends on vse_pkg, vse_if, vse_gather (with vse_ram banks) and vse_classify.
`default_nettype none

// The block keeps one 64-bit occupancy column per (x,y) and answers voxel queries
// with a packed color and a quantized surface normal. A request with mode 0 loads a
// column; with mode 1 it queries one voxel and yields one result when that voxel is
// solid and on the surface, nothing otherwise. Load every column that a query can
// touch before querying it. The block takes one request per clock, loads and queries
// alike, while the result side is not stalled. A query passes through the read of
// nine column banks, the register that holds the gathered 3x3x3 neighborhood and
// the output register. The rate is set by the column store, split into 3x3 banks
// by (x mod 3, y mod 3) so that all nine neighboring columns are read in the same
// cycle, one read per bank. A stalled result holds the pipeline back but the request
// side keeps flowing until every stage is full. Write the configuration registers
// only while no query is in flight.
module voxel_surface_normal_encoder (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [vse_pkg::MAT_W-1:0]     cfg_wdata,
	vse_item_if.sink                           item,
	vse_result_if.source                       result
);

	logic [vse_pkg::DIM_W-1:0] model_width_q, model_height_q, model_depth_q;
	logic [vse_pkg::MAT_W-1:0] emissive_code_q;
	logic [vse_pkg::DIM_W-1:0] w_eff, h_eff, d_eff;

	logic v_s1_q, v_s2_q, out_v_q;
	logic out_free, s2_take, s1_take;
	logic accept, wr_en, rd_en;

	vse_pkg::cube_t   cube_s1;
	vse_pkg::cube_t   cube_s2;
	vse_pkg::result_t res_s2;
	logic [vse_pkg::ENC_W-1:0]    enc_q;
	logic [vse_pkg::NORMAL_W-1:0] normal_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			model_width_q   <= vse_pkg::DIM_W'(64);
			model_height_q  <= vse_pkg::DIM_W'(64);
			model_depth_q   <= vse_pkg::DIM_W'(64);
			emissive_code_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				vse_pkg::CFG_MODEL_WIDTH: begin
					model_width_q <= cfg_wdata[vse_pkg::DIM_W-1:0];
				end
				vse_pkg::CFG_MODEL_HEIGHT: begin
					model_height_q <= cfg_wdata[vse_pkg::DIM_W-1:0];
				end
				vse_pkg::CFG_MODEL_DEPTH: begin
					model_depth_q <= cfg_wdata[vse_pkg::DIM_W-1:0];
				end
				vse_pkg::CFG_EMISSIVE_CODE: begin
					emissive_code_q <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	// Zero acts as one; anything beyond the store saturates.
	assign w_eff = vse_pkg::dim_clamp_f(model_width_q, vse_pkg::MAX_WIDTH);
	assign h_eff = vse_pkg::dim_clamp_f(model_height_q, vse_pkg::MAX_HEIGHT);
	assign d_eff = vse_pkg::dim_clamp_f(model_depth_q, vse_pkg::MAX_DEPTH);

	// Pipeline flow: each stage advances when the stage after it can take its contents.
	assign out_free   = !out_v_q || result.ready;
	assign s2_take    = !v_s2_q || out_free;
	assign s1_take    = !v_s1_q || s2_take;
	assign item.ready = s1_take;
	assign accept     = item.valid && s1_take;

	// Loads write the bank at acceptance and leave the pipeline; drop loads outside the store.
	assign wr_en = accept && (item.mode == vse_pkg::MODE_LOAD)
		&& (vse_pkg::DIM_W'(item.pos_x) < vse_pkg::DIM_W'(vse_pkg::MAX_WIDTH))
		&& (vse_pkg::DIM_W'(item.pos_y) < vse_pkg::DIM_W'(vse_pkg::MAX_HEIGHT));
	assign rd_en = accept && (item.mode == vse_pkg::MODE_QUERY);

	vse_gather u_gather (
		.clk         (clk),
		.wr_en       (wr_en),
		.rd_en       (rd_en),
		.pos_x       (item.pos_x),
		.pos_y       (item.pos_y),
		.pos_z       (item.pos_z),
		.column_bits (item.column_bits),
		.voxel_color (item.voxel_color),
		.w_eff       (w_eff),
		.h_eff       (h_eff),
		.d_eff       (d_eff),
		.cube        (cube_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q  <= 1'b0;
			v_s2_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s1_take) begin
				v_s1_q <= rd_en;
			end
			if (s2_take) begin
				v_s2_q <= v_s1_q;
			end
			// Advance only hits into the output register; drop interior and empty voxels.
			if (out_free) begin
				out_v_q <= v_s2_q && res_s2.hit;
			end
		end
	end

	// Neighborhood register between gather and classify.
	always_ff @(posedge clk) begin
		if (s2_take && v_s1_q) begin
			cube_s2 <= cube_s1;
		end
	end

	vse_classify u_classify (
		.nbhd          (cube_s2),
		.d_eff         (d_eff),
		.emissive_code (emissive_code_q),
		.res           (res_s2)
	);

	// Output register: hold while the result side stalls.
	always_ff @(posedge clk) begin
		if (out_free && v_s2_q) begin
			enc_q    <= res_s2.encoded_color;
			normal_q <= res_s2.normal_code;
		end
	end

	assign result.valid         = out_v_q;
	assign result.encoded_color = enc_q;
	assign result.normal_code   = normal_q;

endmodule

`default_nettype wire
